// ----- rtl/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants for the k-nearest-neighbor list.
// ----------------------------------------------------------------------------
package knn_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int COORD_BITS = 24;
	localparam int DIST_BITS  = 50;
	localparam int IDX_BITS   = 24;
	localparam int K_BITS     = 6;
	localparam int PTR_BITS   = $clog2(LIST_DEPTH);
	localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
	localparam int ROOT_BITS  = 25;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * DIFF_BITS;

	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_NODE   = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_FINISH = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_QX = 2'd0,
		REG_QY = 2'd1,
		REG_QZ = 2'd2,
		REG_K  = 2'd3
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST,
		ST_SUM,
		ST_ROOT,
		ST_NODE_OUT,
		ST_SEARCH,
		ST_SHIFT,
		ST_READ,
		ST_READ_OUT
	} state_t;

	// Controller commands into the datapath.
	typedef struct packed {
		logic load;
		logic sq_step;
		logic sum;
		logic root_start;
		logic root_step;
		logic search_step;
		logic shift_step;
		logic write_new;
		logic read_step;
		logic out_node;
		logic out_entry;
		logic out_empty;
	} knn_cmd_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic sq_done;
		logic root_done;
		logic kth_ready;
		logic search_done;
		logic shift_done;
		logic accept_insert;
		logic list_empty;
		logic read_last;
		logic out_busy;
	} knn_sts_t;

endpackage

// ----- rtl/knn_ctrl.sv -----
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer for clear, node test, insertion and readout.
// ----------------------------------------------------------------------------
module knn_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [1:0]                 in_action,
	output logic                       in_ready,
	input  knn_pkg::knn_sts_t          sts,
	output knn_pkg::knn_cmd_t          cmd
);

	knn_pkg::state_t state_q, state_d;
	logic [1:0] act_q;

	// Hold state and latched action
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= knn_pkg::ST_IDLE;
			act_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) act_q <= in_action;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			knn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_action)
						knn_pkg::ACT_CLEAR:  state_d = knn_pkg::ST_IDLE;
						knn_pkg::ACT_FINISH: state_d = knn_pkg::ST_READ;
						default:             state_d = knn_pkg::ST_DIST;
					endcase
				end
			end
			knn_pkg::ST_DIST: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_done) state_d = knn_pkg::ST_SUM;
			end
			knn_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				if (act_q == knn_pkg::ACT_NODE) state_d = knn_pkg::ST_ROOT;
				else state_d = knn_pkg::ST_SEARCH;
			end
			knn_pkg::ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_done) state_d = knn_pkg::ST_NODE_OUT;
			end
			knn_pkg::ST_NODE_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_node = 1'b1;
					state_d = knn_pkg::ST_IDLE;
				end
			end
			knn_pkg::ST_SEARCH: begin
				if (!sts.accept_insert) state_d = knn_pkg::ST_IDLE;
				else begin
					cmd.search_step = 1'b1;
					if (sts.search_done) state_d = knn_pkg::ST_SHIFT;
				end
			end
			knn_pkg::ST_SHIFT: begin
				if (sts.shift_done) begin
					cmd.write_new  = 1'b1;
					cmd.root_start = 1'b1;
					state_d = knn_pkg::ST_IDLE;
				end else cmd.shift_step = 1'b1;
			end
			knn_pkg::ST_READ: begin
				// Hold until the kth root has settled
				if (!sts.out_busy && sts.kth_ready) begin
					if (sts.list_empty) begin
						cmd.out_empty = 1'b1;
						state_d = knn_pkg::ST_IDLE;
					end else begin
						cmd.read_step = 1'b1;
						state_d = knn_pkg::ST_READ_OUT;
					end
				end
			end
			knn_pkg::ST_READ_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_entry = 1'b1;
					if (sts.read_last) state_d = knn_pkg::ST_IDLE;
					else state_d = knn_pkg::ST_READ;
				end
			end
			default: state_d = knn_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/knn_datapath.sv -----
// ----------------------------------------------------------------------------
// knn_datapath
// Distance, square root unit, sorted list storage and output register.
// ----------------------------------------------------------------------------
module knn_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [knn_pkg::COORD_BITS-1:0]      cfg_data_c,
	input  logic [knn_pkg::K_BITS-1:0]          cfg_data_k,
	input  logic [1:0]                          in_action,
	input  logic [knn_pkg::COORD_BITS-1:0]      pos_x,
	input  logic [knn_pkg::COORD_BITS-1:0]      pos_y,
	input  logic [knn_pkg::COORD_BITS-1:0]      pos_z,
	input  logic [knn_pkg::DIST_BITS-1:0]       radius_sq,
	input  logic [knn_pkg::IDX_BITS-1:0]        pidx,
	input  knn_pkg::knn_cmd_t                   cmd,
	output knn_pkg::knn_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                o_kind,
	output logic                                o_open,
	output logic [4:0]                          o_rank,
	output logic [knn_pkg::IDX_BITS-1:0]        o_index,
	output logic [knn_pkg::DIST_BITS-1:0]       o_dist,
	output logic [knn_pkg::ROOT_BITS-1:0]       o_kth,
	output logic [knn_pkg::K_BITS-1:0]          o_count,
	output logic                                o_last
);

	localparam int PB = knn_pkg::PTR_BITS;
	localparam int CB = knn_pkg::CNT_BITS;
	localparam int DB = knn_pkg::DIST_BITS;
	localparam int RB = knn_pkg::ROOT_BITS;
	localparam int SQB = knn_pkg::SQ_BITS;
	localparam int DFB = knn_pkg::DIFF_BITS;
	localparam int WB = DB + knn_pkg::IDX_BITS;

	// Configuration registers
	logic signed [knn_pkg::COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [knn_pkg::K_BITS-1:0] kreg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0; qy_q <= '0; qz_q <= '0;
			kreg_q <= knn_pkg::K_BITS'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				knn_pkg::REG_QX: qx_q <= cfg_data_c;
				knn_pkg::REG_QY: qy_q <= cfg_data_c;
				knn_pkg::REG_QZ: qz_q <= cfg_data_c;
				knn_pkg::REG_K:  kreg_q <= cfg_data_k;
				default: ;
			endcase
		end
	end

	// Effective k clamped to 1..LIST_DEPTH
	logic [CB-1:0] k_eff;
	always_comb begin
		if (kreg_q == '0) k_eff = CB'(1);
		else if (32'(kreg_q) > knn_pkg::LIST_DEPTH) k_eff = CB'(knn_pkg::LIST_DEPTH);
		else k_eff = CB'(kreg_q);
	end

	// Item registers
	logic signed [DFB-1:0] dx_q, dy_q, dz_q;
	logic [DB-1:0] rad_q;
	logic [knn_pkg::IDX_BITS-1:0] pidx_q;
	logic [CB-1:0] held_q;
	logic [SQB-1:0] sqx_q, sqy_q, sqz_q;
	logic [1:0] sq_cnt_q;
	logic [DB-1:0] d2_q;

	// Squared distance: one multiplier, one axis per cycle
	logic signed [DFB-1:0] dsel;
	logic [DFB-1:0] dabs;
	logic [SQB-1:0] sq;
	always_comb begin
		case (sq_cnt_q)
			2'd0:    dsel = dx_q;
			2'd1:    dsel = dy_q;
			default: dsel = dz_q;
		endcase
		dabs = dsel[DFB-1] ? DFB'(-dsel) : dsel;
		sq   = SQB'(dabs) * SQB'(dabs);
	end
	logic [SQB+1:0] sum3;
	assign sum3 = (SQB+2)'(sqx_q) + (SQB+2)'(sqy_q) + (SQB+2)'(sqz_q);

	// Square root unit: two roots (distance and radius) plus kth root
	logic [DB-1:0] rt_rem_q [2];
	logic [RB-1:0] rt_res_q [2];
	logic [4:0] rt_cnt_q;
	logic rt_run_q;
	logic [RB-1:0] kth_q;
	logic [DB-1:0] kr_rem_q;
	logic [RB-1:0] kr_res_q;
	logic [4:0] kr_cnt_q;
	logic kr_busy_q;

	// One restoring square root digit
	function automatic logic [DB+RB-1:0] sqrt_step(input logic [DB-1:0] rem,
			input logic [RB-1:0] res, input logic [4:0] cnt);
		logic [DB+1:0] trial;
		logic [DB+1:0] remw;
		logic [DB-1:0] rem_n;
		logic [RB-1:0] res_n;
		begin
			trial = ((DB+2)'(res) << (6'(cnt) + 6'd1)) |
				((DB+2)'(1) << (6'(cnt) << 1));
			remw = (DB+2)'(rem);
			if (remw >= trial) begin
				rem_n = DB'(remw - trial);
				res_n = res | (RB'(1) << cnt);
			end else begin
				rem_n = rem;
				res_n = res;
			end
			sqrt_step = {rem_n, res_n};
		end
	endfunction

	logic [DB+RB-1:0] st0, st1, stk;
	assign st0 = sqrt_step(rt_rem_q[0], rt_res_q[0], rt_cnt_q);
	assign st1 = sqrt_step(rt_rem_q[1], rt_res_q[1], rt_cnt_q);
	assign stk = sqrt_step(kr_rem_q, kr_res_q, kr_cnt_q);

	// List storage (registers; sequential shift one entry per cycle)
	logic [WB-1:0] list_q [knn_pkg::LIST_DEPTH];
	logic [CB-1:0] ptr_q;
	logic [CB-1:0] shf_q;
	logic [CB-1:0] held_eff;
	assign held_eff = (held_q > k_eff) ? k_eff : held_q;

	logic [DB-1:0] last_d2;
	assign last_d2 = (held_eff == '0) ? '0 : list_q[PB'(held_eff - CB'(1))][WB-1 -: DB];

	logic [DB-1:0] ptr_d2;
	assign ptr_d2 = list_q[ptr_q[PB-1:0]][WB-1 -: DB];

	logic [CB-1:0] top;
	assign top = (held_eff < k_eff - CB'(1)) ? held_eff : (k_eff - CB'(1));

	// Position of the farthest entry once the new one is in
	logic [CB-1:0] tail_pos;
	assign tail_pos = (held_eff < k_eff) ? held_eff : (held_eff - CB'(1));

	assign sts.sq_done      = (sq_cnt_q == 2'd2);
	assign sts.root_done    = !rt_run_q && !kr_busy_q;
	assign sts.kth_ready    = !kr_busy_q;
	assign sts.search_done  = (ptr_q >= held_eff) || (ptr_d2 > d2_q);
	assign sts.shift_done   = (shf_q <= ptr_q);
	assign sts.accept_insert = (held_eff < k_eff) || (d2_q < last_d2);
	assign sts.list_empty   = (held_eff == '0);
	assign sts.read_last    = (ptr_q + CB'(1) == held_eff);
	assign sts.out_busy     = out_valid && !out_ready;

	// Decision from the two roots
	logic open_dec;
	assign open_dec = (held_eff < k_eff) ||
		!((RB+1)'(rt_res_q[0]) > (RB+1)'(rt_res_q[1]) + (RB+1)'(kth_q));

	logic [WB-1:0] rd_q;

	// Main datapath sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			out_valid <= 1'b0;
			kth_q     <= '0;
			kr_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
			rt_cnt_q  <= '0;
			rt_run_q  <= 1'b0;
			kr_cnt_q  <= '0;
			ptr_q     <= '0;
			shf_q     <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			// Accept an item
			if (cmd.load) begin
				dx_q     <= DFB'(qx_q) - DFB'($signed(pos_x));
				dy_q     <= DFB'(qy_q) - DFB'($signed(pos_y));
				dz_q     <= DFB'(qz_q) - DFB'($signed(pos_z));
				rad_q    <= radius_sq;
				pidx_q   <= pidx;
				sq_cnt_q <= '0;
				ptr_q    <= '0;
				if (in_action == knn_pkg::ACT_CLEAR) begin
					held_q    <= '0;
					kth_q     <= '0;
					kr_busy_q <= 1'b0;
				end else if (held_q != held_eff) begin
					held_q <= held_eff;
					kr_rem_q  <= last_d2;
					kr_res_q  <= '0;
					kr_cnt_q  <= 5'(RB - 1);
					kr_busy_q <= 1'b1;
				end
			end
			// Square one axis
			if (cmd.sq_step) begin
				case (sq_cnt_q)
					2'd0:    sqx_q <= sq;
					2'd1:    sqy_q <= sq;
					default: sqz_q <= sq;
				endcase
				if (sq_cnt_q != 2'd2) sq_cnt_q <= sq_cnt_q + 2'd1;
			end
			// Saturating sum, start roots
			if (cmd.sum) begin
				d2_q <= (sum3 > (SQB+2)'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : DB'(sum3);
				rt_rem_q[0] <= (sum3 > (SQB+2)'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : DB'(sum3);
				rt_rem_q[1] <= rad_q;
				rt_res_q[0] <= '0;
				rt_res_q[1] <= '0;
				rt_cnt_q    <= 5'(RB - 1);
				rt_run_q    <= 1'b1;
			end
			// One digit of both roots per cycle, last digit at count zero
			if (cmd.root_step && rt_run_q) begin
				rt_rem_q[0] <= st0[DB+RB-1:RB];
				rt_res_q[0] <= st0[RB-1:0];
				rt_rem_q[1] <= st1[DB+RB-1:RB];
				rt_res_q[1] <= st1[RB-1:0];
				if (rt_cnt_q == 5'd0) rt_run_q <= 1'b0;
				else rt_cnt_q <= rt_cnt_q - 5'd1;
			end
			if (cmd.out_node) begin
				o_kind  <= 1'b0;
				o_open  <= open_dec;
				o_rank  <= '0;
				o_index <= '0;
				o_dist  <= '0;
				o_kth   <= kth_q;
				o_count <= knn_pkg::K_BITS'(held_eff);
				o_last  <= 1'b0;
				out_valid <= 1'b1;
			end
			// Kth root engine, paused in the cycle an item is taken
			if (kr_busy_q && !cmd.load) begin
				kr_rem_q <= stk[DB+RB-1:RB];
				kr_res_q <= stk[RB-1:0];
				if (kr_cnt_q == 5'd0) begin
					kth_q     <= stk[RB-1:0];
					kr_busy_q <= 1'b0;
				end else kr_cnt_q <= kr_cnt_q - 5'd1;
			end
			// Search insert position
			if (cmd.search_step) begin
				if (sts.search_done) shf_q <= top;
				else ptr_q <= ptr_q + CB'(1);
			end
			// Shift tail down one entry
			if (cmd.shift_step) begin
				list_q[PB'(shf_q)] <= list_q[PB'(shf_q - CB'(1))];
				shf_q <= shf_q - CB'(1);
			end
			// Write new entry, refresh kth root
			if (cmd.write_new) begin
				if (32'(ptr_q) < knn_pkg::LIST_DEPTH)
					list_q[PB'(ptr_q)] <= {d2_q, pidx_q};
				if (held_eff < k_eff) held_q <= held_eff + CB'(1);
				else held_q <= held_eff;
			end
			if (cmd.root_start) begin
				kr_busy_q <= 1'b1;
				kr_cnt_q  <= 5'(RB - 1);
				kr_res_q  <= '0;
				// Tail is already shifted unless the new entry lands there
				if (ptr_q == tail_pos) kr_rem_q <= d2_q;
				else kr_rem_q <= list_q[PB'(tail_pos)][WB-1 -: DB];
			end
			// Readout
			if (cmd.read_step) rd_q <= list_q[ptr_q[PB-1:0]];
			if (cmd.out_entry) begin
				o_kind  <= 1'b1;
				o_open  <= 1'b0;
				o_rank  <= 5'(ptr_q);
				o_index <= rd_q[knn_pkg::IDX_BITS-1:0];
				o_dist  <= rd_q[WB-1 -: DB];
				o_kth   <= kth_q;
				o_count <= knn_pkg::K_BITS'(held_eff);
				o_last  <= sts.read_last;
				out_valid <= 1'b1;
				ptr_q   <= ptr_q + CB'(1);
			end
			if (cmd.out_empty) begin
				o_kind  <= 1'b1;
				o_open  <= 1'b0;
				o_rank  <= '0;
				o_index <= '0;
				o_dist  <= '0;
				o_kth   <= '0;
				o_count <= '0;
				o_last  <= 1'b1;
				out_valid <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/knn_sorted_list_with_prune.sv -----
// Particle: the three axes are squared in turn, then the list is searched for
// the insert position and the tail is shifted; node test: 25-digit square root
// unit, also waiting on the kth-root unit. Readout reads each list entry into
// a register and then presents it, once the kth root has settled. One item in
// work at a time.
// Reset: query at origin, k = 8, list empty; list storage is not cleared.
// ----------------------------------------------------------------------------
// knn_sorted_list_with_prune
// Sorted k-nearest list with node pruning test, controller plus datapath.
// ----------------------------------------------------------------------------
module knn_sorted_list_with_prune (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], node_radius_sq[121:72],
	// particle_index[145:122], zero pad
	input  logic [151:0] s_tdata,
	input  logic [1:0]   s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: neighbor_rank[4:0], neighbor_index[28:5], neighbor_dist_sq[78:29],
	// kth_distance[103:79], found_count[109:104], zero pad
	output logic [111:0] m_tdata,
	output logic [1:0]   m_tuser,  // result_kind[0], open_node[1]
	output logic         m_tlast
);

	knn_pkg::knn_cmd_t cmd;
	knn_pkg::knn_sts_t sts;
	logic o_kind, o_open, o_last;
	logic [4:0] o_rank;
	logic [23:0] o_index;
	logic [49:0] o_dist;
	logic [24:0] o_kth;
	logic [5:0] o_count;

	knn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_action(s_tuser),
		.in_ready(s_tready), .sts(sts), .cmd(cmd)
	);

	knn_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data_c(cfg_data), .cfg_data_k(cfg_data[5:0]), .in_action(s_tuser),
		.pos_x(s_tdata[23:0]), .pos_y(s_tdata[47:24]), .pos_z(s_tdata[71:48]),
		.radius_sq(s_tdata[121:72]), .pidx(s_tdata[145:122]),
		.cmd(cmd), .sts(sts), .out_valid(m_tvalid), .out_ready(m_tready),
		.o_kind(o_kind), .o_open(o_open), .o_rank(o_rank), .o_index(o_index),
		.o_dist(o_dist), .o_kth(o_kth), .o_count(o_count), .o_last(o_last)
	);

	// Pack result item
	assign m_tdata = {2'b00, o_count, o_kth, o_dist, o_index, o_rank};
	assign m_tuser = {o_open, o_kind};
	assign m_tlast = o_last;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, node-test, particle and finish items into the nearest-neighbor
// list under random idling on both stream sides. A local predictor keeps its
// own sorted list and query point and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 250;
	localparam int SETTLE = 100;

	typedef struct {
		bit        kind;
		bit        open;
		bit [4:0]  rank;
		bit [23:0] idx;
		bit [49:0] d2;
		bit [24:0] kth;
		bit [5:0]  found;
		bit        last;
	} nb_result_t;

	typedef struct {
		knn_pkg::action_t   act;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		bit [49:0]         r2;
		bit [23:0]         idx;
		bit                typed;
		nb_result_t        want;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [23:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	knn_sorted_list_with_prune dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// predictor state
	logic signed [23:0] qry_x, qry_y, qry_z;
	bit [5:0]  k_reg;
	bit [49:0] lst_d2[knn_pkg::LIST_DEPTH];
	bit [23:0] lst_idx[knn_pkg::LIST_DEPTH];
	int        held;

	nb_result_t pending[$];
	stim_row_t  stim_rows[$];
	int         errors;
	int         items_sent;
	int         cycles;
	bit         calm;

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned sq_delta(logic signed [23:0] a, logic signed [23:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0) d = -d;
		return longint'(d) * longint'(d);
	endfunction

	function automatic bit [49:0] dist_to_query(stim_row_t r);
		longint unsigned s;
		s = sq_delta(qry_x, r.x) + sq_delta(qry_y, r.y) + sq_delta(qry_z, r.z);
		if (s > 64'h3FFFFFFFFFFFF) s = 64'h3FFFFFFFFFFFF;
		return s[49:0];
	endfunction

	function automatic bit [24:0] kth_root();
		longint unsigned v;
		if (held == 0) return 0;
		v = int_sqrt(longint'(lst_d2[held-1]));
		return v[24:0];
	endfunction

	function automatic nb_result_t make_result(bit kind, bit open, int rank, bit [23:0] idx,
			bit [49:0] d2, bit last);
		nb_result_t r;
		r.kind = kind;
		r.open = open;
		r.rank = rank[4:0];
		r.idx = idx;
		r.d2 = d2;
		r.kth = kth_root();
		r.found = held[5:0];
		r.last = last;
		return r;
	endfunction

	// advance the list by one accepted item and queue what it yields
	task automatic predict_item(stim_row_t r);
		int k, i, j, top;
		bit [49:0] d2;
		longint unsigned dr, rr;
		bit open;
		k = k_reg;
		if (k < 1) k = 1;
		if (k > knn_pkg::LIST_DEPTH) k = knn_pkg::LIST_DEPTH;
		if (r.act == knn_pkg::ACT_CLEAR) begin
			held = 0;
			return;
		end
		if (held > k) held = k;
		case (r.act)
			knn_pkg::ACT_NODE: begin
				open = 1;
				if (held >= k) begin
					dr = int_sqrt(longint'(dist_to_query(r)));
					rr = int_sqrt(longint'(r.r2));
					if (dr > rr + longint'(kth_root())) open = 0;
				end
				pending.push_back(make_result(0, open, 0, 0, 0, 0));
			end
			knn_pkg::ACT_INSERT: begin
				d2 = dist_to_query(r);
				if (held < k || d2 < lst_d2[held-1]) begin
					for (i = 0; i < held; i++)
						if (lst_d2[i] > d2) break;
					top = (held < k - 1) ? held : k - 1;
					for (j = top; j > i; j--) begin
						lst_d2[j] = lst_d2[j-1];
						lst_idx[j] = lst_idx[j-1];
					end
					if (i < knn_pkg::LIST_DEPTH) begin
						lst_d2[i] = d2;
						lst_idx[i] = r.idx;
					end
					if (held < k) held++;
				end
			end
			default: begin
				if (held == 0)
					pending.push_back(make_result(1, 0, 0, 0, 0, 1));
				else
					for (i = 0; i < held; i++)
						pending.push_back(make_result(1, 0, i, lst_idx[i], lst_d2[i],
							i + 1 == held));
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("tb_top: mismatch %s want %0h got %0h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		nb_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				report_mismatch("unexpected item", 0, m_tdata[103:79]);
			end else begin
				w = pending.pop_front();
				if (m_tuser[0] != w.kind) report_mismatch("result_kind", w.kind, m_tuser[0]);
				if (m_tuser[1] != w.open) report_mismatch("open_node", w.open, m_tuser[1]);
				if (m_tdata[4:0] != w.rank) report_mismatch("rank", w.rank, m_tdata[4:0]);
				if (m_tdata[28:5] != w.idx) report_mismatch("index", w.idx, m_tdata[28:5]);
				if (m_tdata[78:29] != w.d2) report_mismatch("dist_sq", w.d2, m_tdata[78:29]);
				if (m_tdata[103:79] != w.kth) report_mismatch("kth", w.kth, m_tdata[103:79]);
				if (m_tdata[109:104] != w.found)
					report_mismatch("found", w.found, m_tdata[109:104]);
				if (m_tlast != w.last) report_mismatch("last", w.last, m_tlast);
			end
		end
	end

	// receiver stalls: mostly short, a few long, none while calm
	int stall_left;
	always @(posedge clk) begin
		int p;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 65) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left <= (p < 93) ? $urandom_range(0, 3) : $urandom_range(10, 40);
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(stim_row_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.act;
		s_tdata <= {6'd0, r.idx, r.r2, r.z, r.y, r.x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (r.typed) begin
			predict_item(r);
			void'(pending.pop_back());
			pending.push_back(r.want);
		end else begin
			predict_item(r);
		end
		items_sent++;
	endtask

	// hold until every result is in, then let a particle in flight finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_query(logic [23:0] qx, logic [23:0] qy, logic [23:0] qz, bit [5:0] k);
		cfg_we <= 1'b1;
		cfg_index <= knn_pkg::REG_QX;
		cfg_data <= qx;
		@(posedge clk);
		cfg_index <= knn_pkg::REG_QY;
		cfg_data <= qy;
		@(posedge clk);
		cfg_index <= knn_pkg::REG_QZ;
		cfg_data <= qz;
		@(posedge clk);
		cfg_index <= knn_pkg::REG_K;
		cfg_data <= {18'd0, k};
		@(posedge clk);
		cfg_we <= 1'b0;
		qry_x = qx;
		qry_y = qy;
		qry_z = qz;
		k_reg = k;
		@(posedge clk);
	endtask

	function automatic stim_row_t row(knn_pkg::action_t a, int x, int y, int z, bit [49:0] r2,
			bit [23:0] idx);
		stim_row_t r;
		r.act = a;
		r.x = x[23:0];
		r.y = y[23:0];
		r.z = z[23:0];
		r.r2 = r2;
		r.idx = idx;
		r.typed = 0;
		r.want = '{default: 0};
		return r;
	endfunction

	function automatic stim_row_t typed_row(stim_row_t r, bit kind, bit open, bit last);
		r.typed = 1;
		r.want.kind = kind;
		r.want.open = open;
		r.want.last = last;
		return r;
	endfunction

	function automatic logic [23:0] near(logic [23:0] c);
		int span;
		span = 1 << $urandom_range(4, 20);
		return c + 24'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic bit [49:0] rand_r2();
		bit [49:0] v;
		v = 50'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: v = v >> $urandom_range(20, 49);
			1: v = v >> $urandom_range(0, 19);
			2: v = '1;
			default: v = v;
		endcase
		return v;
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t r;
		int p;
		p = $urandom_range(0, 99);
		r = row(knn_pkg::ACT_INSERT, 0, 0, 0, rand_r2(), 24'($urandom));
		if (p < 12) begin
			r.act = p < 6 ? knn_pkg::ACT_INSERT : knn_pkg::ACT_NODE;
			r.x = 24'($urandom);
			r.y = 24'($urandom);
			r.z = 24'($urandom);
			return r;
		end
		r.x = near(qry_x);
		r.y = near(qry_y);
		r.z = near(qry_z);
		if (p < 65) r.act = knn_pkg::ACT_INSERT;
		else if (p < 87) r.act = knn_pkg::ACT_NODE;
		else if (p < 91) r.act = knn_pkg::ACT_CLEAR;
		else r.act = knn_pkg::ACT_FINISH;
		return r;
	endfunction

	initial begin
		int phase, n;
		logic [23:0] qv[3];
		bit [5:0] kv;
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= knn_pkg::REG_QX;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= knn_pkg::ACT_CLEAR;
		m_tready <= 1'b0;
		stall_left = 0;
		cycles = 0;
		errors = 0;
		items_sent = 0;
		calm = 0;
		qry_x = 0;
		qry_y = 0;
		qry_z = 0;
		k_reg = 8;
		held = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: reset state, coordinate extremes, ties, prune and readout
		stim_rows.push_back(typed_row(row(knn_pkg::ACT_FINISH, 0, 0, 0, 0, 0), 1, 0, 1));
		stim_rows.push_back(typed_row(row(knn_pkg::ACT_NODE, 8388607, 8388607, 8388607,
			0, 0), 0, 1, 0));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 8388607, 8388607, 8388607, 0,
			24'hFFFFFF));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, -8388608, -8388608, -8388608, 0, 0));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 0, 0, 0, '1, 1));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 4096, 0, 0, 0, 2));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 0, 4096, 0, 0, 3));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 0, 0, -4096, 0, 4));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 100, 100, 100, 0, 5));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, -1, -1, -1, 0, 6));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, -4096, 0, 0, 0, 7));
		stim_rows.push_back(row(knn_pkg::ACT_INSERT, 8388607, -8388608, 8388607, 0, 8));
		stim_rows.push_back(row(knn_pkg::ACT_NODE, -8388608, -8388608, -8388608, 0, 0));
		stim_rows.push_back(row(knn_pkg::ACT_NODE, -8388608, -8388608, -8388608, '1, 0));
		stim_rows.push_back(row(knn_pkg::ACT_NODE, 0, 0, 0, 0, 0));
		stim_rows.push_back(row(knn_pkg::ACT_FINISH, 0, 0, 0, 0, 0));
		stim_rows.push_back(row(knn_pkg::ACT_FINISH, 0, 0, 0, 0, 0));
		stim_rows.push_back(row(knn_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
		stim_rows.push_back(typed_row(row(knn_pkg::ACT_FINISH, 0, 0, 0, 0, 0), 1, 0, 1));
		stim_rows.push_back(typed_row(row(knn_pkg::ACT_NODE, 0, 0, 0, '1, 0), 0, 1, 0));
		foreach (stim_rows[i]) send_item(stim_rows[i]);

		// random phases, each with a fresh query and k, written while idle
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			drain();
			calm = (phase % 4 == 3);
			foreach (qv[i]) begin
				case ($urandom_range(0, 5))
					0: qv[i] = 24'h7FFFFF;
					1: qv[i] = 24'h800000;
					default: qv[i] = 24'($urandom);
				endcase
			end
			if (phase == 0) kv = 1;
			else if (phase == 1) kv = 32;
			else kv = 6'($urandom_range(1, 32));
			write_query(qv[0], qv[1], qv[2], kv);
			// keep the old list now and then so a smaller k cuts it
			if (phase < 2 || $urandom_range(0, 2) != 0)
				send_item(row(knn_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
			n = $urandom_range(8, 50);
			repeat (n) send_item(random_row());
			send_item(row(knn_pkg::ACT_FINISH, 0, 0, 0, 0, 0));
			phase++;
		end
		s_tvalid <= 1'b0;

		// wait out the last results
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
